>>> design/bst_pkg.sv
// Shared types and constants for the binary search table unit.
package bst_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int LOW_W   = 11;
  localparam int UP_W    = 11;
  localparam int BOUND_W = ADDR_W + 2;
  localparam int IN_W    = IDX_W + DATA_W + LOW_W + UP_W;
  localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_BYTES_W = ((IDX_W + 7) / 8) * 8;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic signed [DATA_W-1:0]  word_t;
  typedef logic signed [BOUND_W-1:0] bound_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } ram_req_t;

  localparam bound_t HI_MAX = BOUND_W'(DEPTH - 1);

  function automatic addr_t mid_of(input bound_t lo, input bound_t hi);
    bound_t span;
    bound_t sum;
    span = hi - lo;
    sum  = lo + (span >>> 1);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

>>> design/bst_ram.sv
// Table memory: one write port, one registered read port.
module bst_ram
  import bst_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output word_t    rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> design/bst_seq.sv
// Search sequencer: bounds, midpoint and compare unit, result register.
module bst_seq
  import bst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_valid,
  output logic                    s_ready,
  input  logic                    action,
  input  logic [IDX_W-1:0]        entry_index,
  input  word_t                   value,
  input  logic [LOW_W-1:0]        lower_index,
  input  logic signed [UP_W-1:0]  upper_index,
  output ram_req_t                ram_req,
  input  word_t                   rdata,
  output logic                    m_valid,
  input  logic                    m_ready,
  output logic                    found,
  output logic [IDX_W-1:0]        position
);

  state_t state, state_next;

  bound_t lo, hi;
  addr_t  mid;
  word_t  key;
  logic   res_found;
  addr_t  res_pos;

  logic   out_valid;
  logic   out_found;
  addr_t  out_pos;

  bound_t lo_in, hi_in, hi_cl;
  addr_t  start_mid;
  logic   start_empty;
  logic   accept, search_go;

  logic   hit, below;
  bound_t lo_a, hi_b;
  addr_t  mid_a, mid_b;
  logic   empty_a, empty_b;
  logic   probe_done;
  logic   out_load;

  assign s_ready   = (state == ST_IDLE);
  assign accept    = s_valid && s_ready;
  assign search_go = accept && (action == ACT_SEARCH);

  always_comb begin
    lo_in       = BOUND_W'(lower_index);
    hi_in       = BOUND_W'(upper_index);
    hi_cl       = (hi_in > HI_MAX) ? HI_MAX : hi_in;
    start_mid   = mid_of(lo_in, hi_cl);
    start_empty = (lo_in > hi_cl);

    hit     = (rdata == key);
    below   = (rdata < key);
    lo_a    = BOUND_W'(mid) + bound_t'(1);
    hi_b    = BOUND_W'(mid) - bound_t'(1);
    mid_a   = mid_of(lo_a, hi);
    mid_b   = mid_of(lo, hi_b);
    empty_a = (lo_a > hi);
    empty_b = (lo > hi_b);
    probe_done = hit || (below ? empty_a : empty_b);

    out_load = (state == ST_FINISH) && (!out_valid || m_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (search_go) begin
          state_next = start_empty ? ST_FINISH : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_req.we    = accept && (action == ACT_WRITE);
    ram_req.waddr = entry_index[ADDR_W-1:0];
    ram_req.wdata = value;
    unique case (state)
      ST_PROBE: ram_req.raddr = below ? mid_a : mid_b;
      default:  ram_req.raddr = start_mid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (search_go) begin
          lo        <= lo_in;
          hi        <= hi_cl;
          mid       <= start_mid;
          key       <= value;
          res_found <= 1'b0;
          res_pos   <= '0;
        end
      end
      ST_PROBE: begin
        if (hit) begin
          res_found <= 1'b1;
          res_pos   <= mid;
        end else if (below) begin
          lo  <= lo_a;
          mid <= mid_a;
        end else begin
          hi  <= hi_b;
          mid <= mid_b;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_found <= res_found;
      out_pos   <= res_pos;
    end
  end

  assign m_valid  = out_valid;
  assign found    = out_found;
  assign position = IDX_W'(out_pos);

endmodule

>>> design/binary_search_table_unit.sv
// Top level of the binary search table unit.
//
// Input stream s_axis: s_axis_tuser is the action (0 write entry, 1 search).
// A write beat stores value at entry_index and gives no result beat.
// A search beat runs a binary search for value over the inclusive range
// lower_index..upper_index of the table (upper bound clamped to the table).
// Output stream m_axis: one beat per search, tuser = found, tdata = position
// (zero when not found).
// A search takes one table read per probe, one probe a cycle, from the shared
// midpoint/compare unit and the single read port of the table memory: the
// probe state runs the probes (at most 11 at 1024 entries), then the finish
// state loads the result register; an empty range goes there directly.
// s_axis_tready is low while a search runs; a write leaves it high.
// The result register parts the two sides: new beats are taken while a
// result waits; a finished search holds until that result is taken.
// Reset clears the sequencer and the output valid; table contents are
// undefined until written.
module binary_search_table_unit
  import bst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_index[9:0], value[41:10], lower_index[52:42], upper_index[63:53]
  input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
  // action[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // position[9:0], zeros above
  output logic [OUT_BYTES_W-1:0] m_axis_tdata,
  // found[0]
  output logic                   m_axis_tuser
);

  logic [IDX_W-1:0]       entry_index;
  word_t                  value;
  logic [LOW_W-1:0]       lower_index;
  logic signed [UP_W-1:0] upper_index;
  logic [IDX_W-1:0]       position;
  ram_req_t               ram_req;
  word_t                  rdata;

  assign entry_index = s_axis_tdata[IDX_W-1:0];
  assign value       = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
  assign lower_index = s_axis_tdata[IDX_W+DATA_W+LOW_W-1:IDX_W+DATA_W];
  assign upper_index = s_axis_tdata[IN_W-1:IDX_W+DATA_W+LOW_W];

  bst_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .action      (s_axis_tuser),
    .entry_index (entry_index),
    .value       (value),
    .lower_index (lower_index),
    .upper_index (upper_index),
    .ram_req     (ram_req),
    .rdata       (rdata),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .found       (m_axis_tuser),
    .position    (position)
  );

  bst_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign m_axis_tdata = OUT_BYTES_W'(position);

endmodule

>>> design/bst_checker.sv
// Port-level checks for the binary search table unit, bound to the top level.
module bst_checker
  import bst_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_BYTES_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("position not zero on a miss");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_SEARCH |=> !s_axis_tready)
    else $error("input taken during a search");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_search_table_unit bst_checker u_bst_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
